@@ src/bsf_pkg.sv @@
// Shared widths, defaults and item/config structures for the byte stuffing framer.
package bsf_pkg;

  // Parameter defaults and the largest values the parameters may take.
  localparam int MAX_FRAME_DEF   = 16;
  localparam int MAX_DELIM_DEF   = 4;
  localparam int MAX_FRAME_LIMIT = 64;
  localparam int MAX_DELIM_LIMIT = 8;
  localparam int QUEUE_DEPTH     = 4;

  // Fixed widths that cover every legal parameter value.
  localparam int FL_W  = $clog2(MAX_FRAME_LIMIT + 1);
  localparam int DL_W  = $clog2(MAX_DELIM_LIMIT + 1);
  localparam int PAD_W = $clog2(MAX_FRAME_LIMIT);

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_FRAME_LEN  = 2'd0,
    REG_DELIM_LEN  = 2'd1,
    REG_DELIM_WORD = 2'd2,
    REG_PAD_VALUE  = 2'd3
  } reg_idx_t;

  // One classified input item as it waits between the front and the back.
  typedef struct packed {
    logic [7:0]       data_byte;
    logic             open_flag;
    logic             close_flag;
    logic [PAD_W-1:0] npad;
  } bsf_tok_t;

  // Effective stuffing settings seen by the back end.
  typedef struct packed {
    logic [DL_W-1:0] delim_len;
    logic [31:0]     delim_word;
    logic [7:0]      pad_value;
  } bsf_cfg_t;

endpackage

@@ src/bsf_in_if.sv @@
// Input channel interface: one message byte per item.
interface bsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_end;

  modport source (output valid, output data_byte, output message_end, input ready);
  modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

@@ src/bsf_out_if.sv @@
// Output channel interface: one framed byte per item.
interface bsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       run_last;

  modport source (output valid, output out_byte, output frame_end, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_end, input run_last,
                  output ready);
endinterface

@@ src/byte_stuffing_framer.sv @@
// Top level: configuration registers, front end, item queue and back end.
// Path of a plain item: the queue slot, a feed into the match window, then a scan
// that loads the output register. In the back each payload or pad byte enters the
// match window before it is emitted; a stalled output holds the sequencer. A new
// queued item is taken only once the current one is done. Each flag is delim_len bytes.
// Reset (rst_n low, synchronous) empties queue and window and restores register defaults.
module byte_stuffing_framer
  import bsf_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  parameter int MAX_DELIM = MAX_DELIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bsf_in_if.sink      in_ch,
  bsf_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [4:0]  FRAME_LEN_RST  = 5'd8;
  localparam logic [2:0]  DELIM_LEN_RST  = 3'd1;
  localparam logic [31:0] DELIM_WORD_RST = 32'd126;
  localparam logic [7:0]  PAD_VALUE_RST  = 8'd48;

  logic [4:0]      frame_len_r;
  logic [2:0]      delim_len_r;
  logic [31:0]     delim_word_r;
  logic [7:0]      pad_value_r;
  reg_idx_t        reg_sel;
  logic [FL_W-1:0] fl_eff;
  logic [DL_W-1:0] dl_eff;
  bsf_cfg_t        back_cfg;
  logic            q_push, q_full, q_pop, q_valid;
  bsf_tok_t        push_tok, head_tok;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r  <= FRAME_LEN_RST;
      delim_len_r  <= DELIM_LEN_RST;
      delim_word_r <= DELIM_WORD_RST;
      pad_value_r  <= PAD_VALUE_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_FRAME_LEN:  frame_len_r  <= pwdata[4:0];
        REG_DELIM_LEN:  delim_len_r  <= pwdata[2:0];
        REG_DELIM_WORD: delim_word_r <= pwdata;
        REG_PAD_VALUE:  pad_value_r  <= pwdata[7:0];
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      REG_FRAME_LEN:  prdata = 32'(frame_len_r);
      REG_DELIM_LEN:  prdata = 32'(delim_len_r);
      REG_DELIM_WORD: prdata = delim_word_r;
      REG_PAD_VALUE:  prdata = 32'(pad_value_r);
    endcase
  end

  // Clamp lengths to the supported range: zero acts as one.
  always_comb begin
    if (frame_len_r == '0) begin
      fl_eff = FL_W'(1);
    end else if (FL_W'(frame_len_r) > FL_W'(MAX_FRAME)) begin
      fl_eff = FL_W'(MAX_FRAME);
    end else begin
      fl_eff = FL_W'(frame_len_r);
    end
    if (delim_len_r == '0) begin
      dl_eff = DL_W'(1);
    end else if (DL_W'(delim_len_r) > DL_W'(MAX_DELIM)) begin
      dl_eff = DL_W'(MAX_DELIM);
    end else begin
      dl_eff = DL_W'(delim_len_r);
    end
    back_cfg.delim_len  = dl_eff;
    back_cfg.delim_word = delim_word_r;
    back_cfg.pad_value  = pad_value_r;
  end

  bsf_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .frame_len (fl_eff),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_tok     (push_tok)
  );

  bsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_tok   (push_tok),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_tok   (head_tok)
  );

  bsf_back #(
    .MAX_DELIM (MAX_DELIM)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (back_cfg),
    .q_valid (q_valid),
    .q_tok   (head_tok),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

@@ src/bsf_queue.sv @@
// Short register queue that holds classified items between front and back.
module bsf_queue
  import bsf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  bsf_tok_t push_tok,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output bsf_tok_t head_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bsf_tok_t        slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_tok   = slot_r[rd_ptr_r];

  // Pointer and fill count update; push and pop may happen in the same cycle.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

@@ src/bsf_front.sv @@
// Front end: accepts message bytes and classifies each against the frame position.
module bsf_front
  import bsf_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  bsf_in_if.sink          in_ch,
  input  logic [FL_W-1:0] frame_len,
  input  logic            q_full,
  output logic            q_push,
  output bsf_tok_t        q_tok
);

  localparam int FPW = $clog2(MAX_FRAME + 1);

  logic [FPW-1:0]  pos_r, pos_nxt;
  logic [FPW-1:0]  pos_inc;
  logic [FL_W-1:0] pos_inc_w;
  logic            reach;
  logic            close_now;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && in_ch.ready;

  // Decide opening flag, padding count and frame close for this item.
  always_comb begin
    pos_inc   = pos_r + FPW'(1);
    pos_inc_w = FL_W'(pos_inc);
    reach     = (pos_inc_w >= frame_len);
    close_now = in_ch.message_end || reach;

    q_tok.data_byte  = in_ch.data_byte;
    q_tok.open_flag  = (pos_r == '0);
    q_tok.close_flag = close_now;
    q_tok.npad       = (in_ch.message_end && !reach) ? PAD_W'(frame_len - pos_inc_w) : '0;

    pos_nxt = pos_r;
    if (q_push) begin
      pos_nxt = close_now ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

@@ src/bsf_back.sv @@
// Back end: runs the delimiter matcher and emits flags, stuffed payload and held bytes.
module bsf_back
  import bsf_pkg::*;
#(
  parameter int MAX_DELIM = MAX_DELIM_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  bsf_cfg_t cfg,
  input  logic     q_valid,
  input  bsf_tok_t q_tok,
  output logic     q_pop,
  bsf_out_if.source out_ch
);

  localparam int CW         = $clog2(MAX_DELIM + 1);
  localparam int WORD_BYTES = 4;

  typedef enum logic [2:0] {
    PH_START,
    PH_OPEN,
    PH_FEED,
    PH_SCAN,
    PH_FLUSH,
    PH_CLOSE
  } phase_t;

  phase_t        phase_r, phase_nxt;
  phase_t        ph;
  logic [7:0]    win_r [MAX_DELIM];
  logic [7:0]    win_nxt [MAX_DELIM];
  logic [7:0]    win_s1 [MAX_DELIM];
  logic [7:0]    win_sd [MAX_DELIM];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rep_r, rep_nxt;
  logic          fed_r, fed_nxt;
  logic [PAD_W-1:0] padn_r, padn_nxt;
  logic [PAD_W-1:0] pads_after;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          frame_end_r, frame_end_nxt;
  logic          run_last_r, run_last_nxt;

  logic [CW-1:0] dl_c;
  logic [CW-1:0] dl_m1;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] ca;
  logic [7:0]    feed_byte;
  logic [7:0]    e_byte;
  logic          emit, e_fe, e_last;
  logic          active, out_free, fire;
  logic          hit, fin, more_pads;

  // Delimiter byte i; bytes above the 32-bit word read as zero.
  function automatic logic [7:0] delim_byte(input logic [DL_W-1:0] i, input logic [31:0] w);
    if (i < DL_W'(WORD_BYTES)) begin
      return w[{i[1:0], 3'b000} +: 8];
    end
    return 8'h00;
  endfunction

  // Where to go once the current feed has nothing more to emit.
  function automatic phase_t after_feed(input logic more, input logic close,
                                        input logic [CW-1:0] left);
    if (more) begin
      return PH_FEED;
    end else if (close) begin
      return (left != '0) ? PH_FLUSH : PH_CLOSE;
    end
    return PH_START;
  endfunction

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.frame_end = frame_end_r;
  assign out_ch.run_last  = run_last_r;

  // Window match and the two window shifts.
  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < MAX_DELIM; i++) begin
      if ((CW'(i) < dl_c) && (win_r[i] != delim_byte(DL_W'(i), cfg.delim_word))) begin
        hit = 1'b0;
      end
    end
    win_s1 = win_r;
    for (int i = 0; i + 1 < MAX_DELIM; i++) begin
      win_s1[i] = win_r[i + 1];
    end
    win_sd = win_r;
    for (int k = 1; k < MAX_DELIM; k++) begin
      for (int i = 0; i + k < MAX_DELIM; i++) begin
        if (dl_c == CW'(k)) begin
          win_sd[i] = win_r[i + k];
        end
      end
    end
  end

  // Sequencer: one action per cycle unless a stalled output holds it, at most one emitted byte.
  always_comb begin
    dl_c     = CW'(cfg.delim_len);
    dl_m1    = dl_c - CW'(1);
    cnt_inc  = cnt_r + CW'(1);
    ph       = phase_r;
    if (phase_r == PH_START) begin
      ph = (q_valid && q_tok.open_flag) ? PH_OPEN : PH_FEED;
    end
    active   = (phase_r != PH_START) || q_valid;
    out_free = !out_valid_r || out_ch.ready;
    fire     = active && ((ph == PH_FEED) || out_free);

    phase_nxt = phase_r;
    win_nxt   = win_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    rep_nxt   = rep_r;
    fed_nxt   = fed_r;
    padn_nxt  = padn_r;
    emit      = 1'b0;
    e_byte    = 8'h00;
    e_fe      = 1'b0;
    e_last    = 1'b0;
    fin       = 1'b0;
    ca        = cnt_r;
    q_pop     = 1'b0;
    feed_byte  = fed_r ? cfg.pad_value : q_tok.data_byte;
    pads_after = fed_r ? padn_r + PAD_W'(1) : padn_r;
    more_pads  = 1'b0;

    unique case (ph)
      PH_OPEN: begin
        emit   = 1'b1;
        e_byte = delim_byte(DL_W'(idx_r), cfg.delim_word);
        e_last = (idx_r == dl_m1) && !q_tok.close_flag && (cnt_inc < dl_c);
        if (fire) begin
          if (idx_r == dl_m1) begin
            idx_nxt   = '0;
            phase_nxt = PH_FEED;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            phase_nxt = PH_OPEN;
          end
        end
      end
      PH_FEED: begin
        more_pads = (pads_after < q_tok.npad);
        if (fire) begin
          for (int i = 0; i < MAX_DELIM; i++) begin
            if (cnt_r == CW'(i)) begin
              win_nxt[i] = feed_byte;
            end
          end
          cnt_nxt   = cnt_inc;
          fed_nxt   = 1'b1;
          padn_nxt  = pads_after;
          phase_nxt = (cnt_inc >= dl_c) ? PH_SCAN
                                        : after_feed(more_pads, q_tok.close_flag, cnt_inc);
        end
      end
      PH_SCAN: begin
        more_pads = (padn_r < q_tok.npad);
        emit      = 1'b1;
        if (hit) begin
          // Delimiter found: send it twice, then drop it from the window.
          e_byte = delim_byte(DL_W'(idx_r), cfg.delim_word);
          fin    = rep_r && (idx_r == dl_m1);
          ca     = cnt_r - dl_c;
          e_last = fin && !q_tok.close_flag && (ca < dl_c);
          if (fire) begin
            if (!fin) begin
              if (idx_r == dl_m1) begin
                idx_nxt = '0;
                rep_nxt = 1'b1;
              end else begin
                idx_nxt = idx_r + CW'(1);
              end
            end else begin
              idx_nxt   = '0;
              rep_nxt   = 1'b0;
              win_nxt   = win_sd;
              cnt_nxt   = ca;
              phase_nxt = (ca >= dl_c) ? PH_SCAN : after_feed(more_pads, q_tok.close_flag, ca);
            end
          end
        end else begin
          // No match at the window head: release its oldest byte.
          e_byte = win_r[0];
          ca     = cnt_r - CW'(1);
          e_last = !q_tok.close_flag && (ca < dl_c);
          if (fire) begin
            win_nxt   = win_s1;
            cnt_nxt   = ca;
            phase_nxt = (ca >= dl_c) ? PH_SCAN : after_feed(more_pads, q_tok.close_flag, ca);
          end
        end
      end
      PH_FLUSH: begin
        emit   = 1'b1;
        e_byte = win_r[0];
        ca     = cnt_r - CW'(1);
        if (fire) begin
          win_nxt = win_s1;
          cnt_nxt = ca;
          if (ca == '0) begin
            phase_nxt = PH_CLOSE;
          end
        end
      end
      PH_CLOSE: begin
        emit   = 1'b1;
        e_byte = delim_byte(DL_W'(idx_r), cfg.delim_word);
        e_fe   = (idx_r == dl_m1);
        e_last = (idx_r == dl_m1);
        if (fire) begin
          if (idx_r == dl_m1) begin
            idx_nxt   = '0;
            phase_nxt = PH_START;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      PH_START: begin
        emit = 1'b0;
      end
    endcase

    // Item finished: release its queue entry.
    if (fire && (phase_nxt == PH_START)) begin
      q_pop    = 1'b1;
      fed_nxt  = 1'b0;
      padn_nxt = '0;
    end

    // Output register.
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    frame_end_nxt = frame_end_r;
    run_last_nxt  = run_last_r;
    if (fire && emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = e_byte;
      frame_end_nxt = e_fe;
      run_last_nxt  = e_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      cnt_r       <= '0;
      idx_r       <= '0;
      rep_r       <= 1'b0;
      fed_r       <= 1'b0;
      padn_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      rep_r       <= rep_nxt;
      fed_r       <= fed_nxt;
      padn_r      <= padn_nxt;
      out_valid_r <= out_valid_nxt;
    end
    win_r       <= win_nxt;
    out_byte_r  <= out_byte_nxt;
    frame_end_r <= frame_end_nxt;
    run_last_r  <= run_last_nxt;
  end

  // The window never holds more bytes than it has entries.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_DELIM))
    else $error("match window count out of range");

  // A closing flag always ends the results of its item.
  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_end_r) |-> run_last_r)
    else $error("frame end without run last");

  // Items are released only when the queue holds one.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  // Flushing runs only while held bytes remain.
  a_flush_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FLUSH) |-> (cnt_r != '0))
    else $error("flush with empty window");

endmodule
